[hdl/multi_slot_beacon_scheduler_top_assert.svh]
// Assertion macros for the beacon scheduler top level.
`ifndef MULTI_SLOT_BEACON_SCHEDULER_TOP_ASSERT_SVH
`define MULTI_SLOT_BEACON_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSBS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MSBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/msbs_pkg.sv]
// Shared constants and controller/datapath types for the beacon scheduler.
package msbs_pkg;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_RESIZE  = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] ACT_SEND   = 2'd0;
	localparam logic [1:0] ACT_REPEAT = 2'd1;
	localparam logic [1:0] ACT_STOP   = 2'd2;

	localparam logic [1:0] PHASE_LAST = 2'd2;

	localparam int PHASES      = 3;
	localparam int MAX_RESULTS = 4;
	localparam int TIME_W      = 32;
	localparam int PERIOD_W    = 16;
	localparam int DIV_STEPS   = PERIOD_W;
	localparam int DIV_CW      = $clog2(DIV_STEPS);

	localparam logic [PERIOD_W-1:0] PACK_PERIOD_RST   = 16'd333;
	localparam logic [PERIOD_W-1:0] BEACON_PERIOD_RST = 16'd100;

	localparam logic REG_PACK_PERIOD   = 1'b0;
	localparam logic REG_BEACON_PERIOD = 1'b1;

	typedef struct packed {
		logic capture;
		logic idx_zero;
		logic idx_cnt;
		logic tick_step;
		logic stop_step;
		logic provision;
		logic div_start;
		logic div_step;
		logic stag_start;
		logic stag_step;
		logic flush;
	} msbs_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       op_ok;
		logic       tick_end;
		logic       stop_end;
		logic       stag_end;
		logic       step_ok;
		logic       div_last;
		logic       pend_v;
		logic       push_ok;
	} msbs_sts_t;

endpackage

[hdl/msbs_item_if.sv]
// Input item channel: op, time, finished mask, fleet count, target slot.
interface msbs_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] now;
	logic [3:0]  finished_mask;
	logic [2:0]  fleet_count;
	logic [1:0]  target_slot;

	modport source (
		output valid, op, now, finished_mask, fleet_count, target_slot,
		input  ready
	);
	modport sink (
		input  valid, op, now, finished_mask, fleet_count, target_slot,
		output ready
	);
endinterface

[hdl/msbs_result_if.sv]
// Result channel: slot, action, phase, counter, last.
interface msbs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] slot;
	logic [1:0] action;
	logic [1:0] phase;
	logic [7:0] counter;
	logic       last;

	modport source (
		output valid, slot, action, phase, counter, last,
		input  ready
	);
	modport sink (
		input  valid, slot, action, phase, counter, last,
		output ready
	);
endinterface

[hdl/msbs_cfg.sv]
// APB register block holding the pack and beacon periods.
module msbs_cfg import msbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic [PERIOD_W-1:0] pack_period,
	output logic [PERIOD_W-1:0] beacon_period
);

	logic [PERIOD_W-1:0] pack_period_q;
	logic [PERIOD_W-1:0] beacon_period_q;
	logic                wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_period_q   <= PACK_PERIOD_RST;
			beacon_period_q <= BEACON_PERIOD_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_PACK_PERIOD:   pack_period_q   <= pwdata[PERIOD_W-1:0];
				REG_BEACON_PERIOD: beacon_period_q <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PACK_PERIOD:   prdata = 32'(pack_period_q);
			REG_BEACON_PERIOD: prdata = 32'(beacon_period_q);
			default:           prdata = '0;
		endcase
	end

	assign pack_period   = pack_period_q;
	assign beacon_period = beacon_period_q;

endmodule

[hdl/msbs_ctrl.sv]
// Sequencer: walks ticks, resize stops, period divide and restagger.
module msbs_ctrl import msbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  msbs_sts_t sts,
	output msbs_cmd_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_TICK,
		S_STOP,
		S_DIV,
		S_STAG,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   rdy_q;

	always_comb begin
		ctl = '0;
		nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && rdy_q) begin
					ctl.capture  = 1'b1;
					ctl.idx_zero = 1'b1;
					nxt          = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_TICK: nxt = S_TICK;
					OP_RESIZE: begin
						if (sts.op_ok) begin
							ctl.idx_cnt = 1'b1;
							nxt         = S_STOP;
						end else begin
							nxt = S_FLUSH;
						end
					end
					OP_RESTART: begin
						if (sts.op_ok) begin
							ctl.provision = 1'b1;
							ctl.div_start = 1'b1;
							nxt           = S_DIV;
						end else begin
							nxt = S_FLUSH;
						end
					end
					default: nxt = S_FLUSH;
				endcase
			end
			S_TICK: begin
				if (sts.tick_end) begin
					nxt = S_FLUSH;
				end else if (sts.step_ok) begin
					ctl.tick_step = 1'b1;
				end
			end
			S_STOP: begin
				if (sts.stop_end) begin
					ctl.provision = 1'b1;
					ctl.div_start = 1'b1;
					nxt           = S_DIV;
				end else if (sts.step_ok) begin
					ctl.stop_step = 1'b1;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					ctl.stag_start = 1'b1;
					nxt            = S_STAG;
				end
			end
			S_STAG: begin
				if (sts.stag_end) begin
					nxt = S_FLUSH;
				end else begin
					ctl.stag_step = 1'b1;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_v) begin
					nxt = S_IDLE;
				end else if (sts.push_ok) begin
					ctl.flush = 1'b1;
					nxt       = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= nxt;
			rdy_q   <= (nxt == S_IDLE);
		end
	end

	assign in_ready = rdy_q;

endmodule

[hdl/msbs_dp.sv]
// Datapath: per-slot state, slot walk, period divider, result staging.
module msbs_dp import msbs_pkg::*; #(
	parameter int SLOTS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  msbs_cmd_t           ctl,
	output msbs_sts_t           sts,
	input  logic [1:0]          item_op,
	input  logic [31:0]         item_now,
	input  logic [3:0]          item_finished_mask,
	input  logic [2:0]          item_fleet_count,
	input  logic [1:0]          item_target_slot,
	input  logic [PERIOD_W-1:0] pack_period,
	input  logic [PERIOD_W-1:0] beacon_period,
	msbs_result_if.source       result
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KW = (CW > 3) ? CW : 3;

	// captured item
	logic [1:0]        op_q;
	logic [TIME_W-1:0] now_q;
	logic [3:0]        fin_q;
	logic [2:0]        cnt_q;
	logic [1:0]        tgt_q;

	// slot state
	logic [TIME_W-1:0] pdl_q    [SLOTS];
	logic [TIME_W-1:0] bdl_q    [SLOTS];
	logic [7:0]        mcnt_q   [SLOTS];
	logic [1:0]        phase_q  [SLOTS];
	logic              active_q [SLOTS];
	logic              offair_q [SLOTS];
	logic [2:0]        act_cnt_q;

	logic [CW-1:0]     idx_q;
	logic [2:0]        n_q;

	logic [PERIOD_W-1:0] quo_q;
	logic [2:0]          rem_q;
	logic [DIV_CW-1:0]   dcnt_q;
	logic [3:0]          r2;
	logic                r2_ge;

	logic [TIME_W-1:0] stag_q;

	logic       pend_v_q;
	logic [1:0] pend_slot_q;
	logic [1:0] pend_act_q;
	logic [1:0] pend_ph_q;
	logic [7:0] pend_cnt_q;

	logic       ov_q;
	logic [1:0] o_slot_q;
	logic [1:0] o_act_q;
	logic [1:0] o_ph_q;
	logic [7:0] o_cnt_q;
	logic       o_last_q;

	logic [SW-1:0]     sidx;
	logic [3:0]        fin_sh;
	logic              fin_bit;
	logic              cur_act;
	logic [1:0]        ph;
	logic [1:0]        nph;
	logic [TIME_W-1:0] pdiff;
	logic [TIME_W-1:0] bdiff;
	logic              pass_p;
	logic              pass_b;
	logic [TIME_W-1:0] pack_due;
	logic [TIME_W-1:0] beacon_due;
	logic              t_has;
	logic [1:0]        t_act;
	logic              is_tick;
	logic              res_has;
	logic [1:0]        res_act;
	logic [1:0]        res_ph;
	logic [7:0]        res_cnt;
	logic              emit;
	logic              walk_step;
	logic              emit_step;
	logic              push_ok;
	logic              push_mid;

	// slot walk decode
	assign sidx    = idx_q[SW-1:0];
	assign fin_sh  = fin_q >> idx_q;
	assign fin_bit = fin_sh[0];
	assign cur_act = active_q[sidx];
	assign ph      = (phase_q[sidx] == 2'd3) ? PHASE_LAST : phase_q[sidx];
	assign nph     = (ph == PHASE_LAST) ? 2'd0 : ph + 2'd1;
	assign pdiff   = now_q - pdl_q[sidx];
	assign bdiff   = now_q - bdl_q[sidx];
	assign pass_p  = ~pdiff[TIME_W-1];
	assign pass_b  = ~bdiff[TIME_W-1];

	assign pack_due   = now_q + TIME_W'(pack_period);
	assign beacon_due = now_q + TIME_W'(beacon_period);

	assign t_has = cur_act && (fin_bit ? !offair_q[sidx] : (pass_p || pass_b));
	assign t_act = fin_bit ? ACT_STOP : (pass_p ? ACT_SEND : ACT_REPEAT);

	assign is_tick = (op_q == OP_TICK);
	assign res_has = is_tick ? t_has : cur_act;
	assign res_act = is_tick ? t_act : ACT_STOP;
	assign res_ph  = (is_tick && !fin_bit && pass_p) ? ph : 2'd0;
	assign res_cnt = (is_tick && !fin_bit && pass_p) ? mcnt_q[sidx] : 8'd0;

	assign emit      = res_has && (n_q < 3'(MAX_RESULTS));
	assign walk_step = ctl.tick_step || ctl.stop_step;
	assign emit_step = walk_step && emit;
	assign push_ok   = !ov_q || result.ready;
	assign push_mid  = emit_step && pend_v_q;

	// divider: pack_period / active count, one quotient bit per cycle
	assign r2    = {rem_q, quo_q[PERIOD_W-1]};
	assign r2_ge = (r2 >= {1'b0, act_cnt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_TICK;
		end else if (ctl.capture) begin
			op_q <= item_op;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			now_q <= item_now;
			fin_q <= item_finished_mask;
			cnt_q <= item_fleet_count;
			tgt_q <= item_target_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.idx_zero || ctl.stag_start) begin
			idx_q <= '0;
		end else if (ctl.idx_cnt) begin
			idx_q <= CW'(cnt_q);
		end else if (walk_step || ctl.stag_step) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (ctl.capture) begin
			n_q <= '0;
		end else if (emit_step) begin
			n_q <= n_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cnt_q <= 3'd1;
		end else if (ctl.provision && (op_q == OP_RESIZE)) begin
			act_cnt_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (ctl.div_start) begin
			dcnt_q <= DIV_CW'(DIV_STEPS - 1);
		end else if (ctl.div_step) begin
			dcnt_q <= dcnt_q - DIV_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			quo_q <= pack_period;
			rem_q <= '0;
		end else if (ctl.div_step) begin
			quo_q <= {quo_q[PERIOD_W-2:0], r2_ge};
			rem_q <= r2_ge ? 3'(r2 - {1'b0, act_cnt_q}) : r2[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.stag_start) begin
			stag_q <= now_q;
		end else if (ctl.stag_step) begin
			stag_q <= stag_q + TIME_W'(quo_q);
		end
	end

	for (genvar s = 0; s < SLOTS; s++) begin : g_slot
		localparam logic [1:0] PH0 = 2'(s % PHASES);
		logic sel;
		logic prov;

		assign sel  = (idx_q == CW'(s));
		assign prov = ctl.provision &&
			(((op_q == OP_RESIZE) && (KW'(s) < KW'(cnt_q))) ||
			 ((op_q == OP_RESTART) && (KW'(s) == KW'(tgt_q))));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pdl_q[s]    <= '0;
				bdl_q[s]    <= '0;
				mcnt_q[s]   <= '0;
				phase_q[s]  <= '0;
				active_q[s] <= (s == 0);
				offair_q[s] <= 1'b0;
			end else if (prov) begin
				mcnt_q[s]   <= '0;
				phase_q[s]  <= PH0;
				active_q[s] <= 1'b1;
				offair_q[s] <= 1'b0;
			end else if (sel && ctl.stop_step) begin
				active_q[s] <= 1'b0;
			end else if (sel && ctl.tick_step && active_q[s]) begin
				if (fin_bit) begin
					offair_q[s] <= 1'b1;
				end else begin
					offair_q[s] <= 1'b0;
					if (pass_p) begin
						mcnt_q[s]  <= mcnt_q[s] + 8'd1;
						phase_q[s] <= nph;
						pdl_q[s]   <= pack_due;
						bdl_q[s]   <= beacon_due;
					end else if (pass_b) begin
						bdl_q[s] <= beacon_due;
					end
				end
			end else if (sel && ctl.stag_step) begin
				pdl_q[s] <= stag_q;
				bdl_q[s] <= stag_q;
			end
		end
	end

	// one result held back so the final beat can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (emit_step) begin
			pend_v_q <= 1'b1;
		end else if (ctl.flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			pend_slot_q <= 2'(idx_q);
			pend_act_q  <= res_act;
			pend_ph_q   <= res_ph;
			pend_cnt_q  <= res_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (push_mid || ctl.flush) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid || ctl.flush) begin
			o_slot_q <= pend_slot_q;
			o_act_q  <= pend_act_q;
			o_ph_q   <= pend_ph_q;
			o_cnt_q  <= pend_cnt_q;
			o_last_q <= ctl.flush;
		end
	end

	assign result.valid   = ov_q;
	assign result.slot    = o_slot_q;
	assign result.action  = o_act_q;
	assign result.phase   = o_ph_q;
	assign result.counter = o_cnt_q;
	assign result.last    = o_last_q;

	always_comb begin
		sts          = '0;
		sts.op       = op_q;
		case (op_q)
			OP_RESIZE:  sts.op_ok = (cnt_q != 3'd0) && (KW'(cnt_q) <= KW'(SLOTS));
			OP_RESTART: sts.op_ok = (KW'(tgt_q) < KW'(act_cnt_q));
			default:    sts.op_ok = 1'b0;
		endcase
		sts.tick_end = (KW'(idx_q) >= KW'(act_cnt_q));
		sts.stag_end = (KW'(idx_q) >= KW'(act_cnt_q));
		sts.stop_end = (idx_q == CW'(SLOTS));
		sts.step_ok  = !emit || !pend_v_q || push_ok;
		sts.div_last = (dcnt_q == '0);
		sts.pend_v   = pend_v_q;
		sts.push_ok  = push_ok;
	end

endmodule

[hdl/multi_slot_beacon_scheduler_top.sv]
// Top level of the multi-slot beacon scheduler.
//
//  channel   dir   handshake            beat contents
//  item      in    valid/ready          op, now, finished_mask, fleet_count, target_slot
//  result    out   valid/ready          slot, action, phase, counter, last
//  apb       in    psel/penable/pready  pack_period @0x0, beacon_period @0x4
//
// One item at a time. A tick walks the active slots, one slot per cycle when not
// stalled; resize and restart run the bit-serial pack_period / count divider
// before restagger. Rejected resize or restart and unused ops go straight to flush.
// A result waiting in the output register stalls the slot walk only when a new
// result must move past it; the next item is taken while the final beat waits.
// arst_n clears control and slot state to slot 0 active, count one.
`include "multi_slot_beacon_scheduler_top_assert.svh"

module multi_slot_beacon_scheduler_top import msbs_pkg::*; #(
	parameter int SLOTS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	msbs_item_if.sink    item,
	msbs_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	msbs_cmd_t           ctl;
	msbs_sts_t           sts;
	logic                in_rdy;
	logic [PERIOD_W-1:0] pack_period;
	logic [PERIOD_W-1:0] beacon_period;

	msbs_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pack_period   (pack_period),
		.beacon_period (beacon_period)
	);

	msbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_rdy),
		.sts      (sts),
		.ctl      (ctl)
	);

	msbs_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.sts                (sts),
		.item_op            (item.op),
		.item_now           (item.now),
		.item_finished_mask (item.finished_mask),
		.item_fleet_count   (item.fleet_count),
		.item_target_slot   (item.target_slot),
		.pack_period        (pack_period),
		.beacon_period      (beacon_period),
		.result             (result)
	);

	assign item.ready = in_rdy;

	`MSBS_ASSERT_SAME(a_idle_no_pend, item.ready, !sts.pend_v, "held result left at idle")
	`MSBS_ASSERT_SAME(a_step_gated, ctl.tick_step || ctl.stop_step, sts.step_ok, "walk past stall")
	`MSBS_ASSERT_NEXT(a_div_ends, ctl.div_step && sts.div_last, !ctl.div_step, "divider overran")
	`MSBS_ASSERT_NEXT(a_one_item, item.valid && item.ready, !item.ready, "second item taken")

endmodule
